/* rtl/ioc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared types and constants of the in-order completion ring.
// ----------------------------------------------------------------------------
package ioc_pkg;

  localparam int CAP_W          = 9;
  localparam int SLOT_W         = 8;
  localparam int VAL_W          = 64;
  localparam int CNT_W          = 9;
  localparam int DEF_DEPTH      = 256;
  localparam int DEF_DATA_WIDTH = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 88;
  localparam int TUSER_W   = 2;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_COMPLETE = 2'd2,
    ACT_RETIRE   = 2'd3
  } ioc_action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } ioc_status_e;

  typedef struct packed {
    ioc_status_e       status;
    logic [SLOT_W-1:0] out_slot;
    logic [VAL_W-1:0]  out_value;
    logic [CNT_W-1:0]  retired_count;
  } ioc_res_t;

endpackage

/* rtl/in_order_completion_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_completion_ring
// Reorder ring: in-order dispatch, out-of-order complete, in-order retire.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid/tready            tuser: action; tdata: block_value, slot
// m_axis    out  tvalid/tready            tuser: status; tdata: slot, value, count
// cfg       in   cfg_valid_i/cfg_ready_o  cfg_data_i: capacity
//
// Push, dispatch and complete: accept, then emit. Retire: accept, a walk over
// the freed slots, then emit; the done-bit memory port reads one slot per cycle.
// Reset or a capacity write empties the ring; no clearing pass is needed.
// A stalled m_axis holds the last result while the next word is accepted.
// ----------------------------------------------------------------------------
module in_order_completion_ring #(
  parameter int DEPTH      = ioc_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = ioc_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // block_value[63:0], slot[71:64]
  input  logic [ioc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  logic [ioc_pkg::TUSER_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_slot[7:0], out_value[71:8], retired_count[80:72], zero fill
  output logic [ioc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [ioc_pkg::TUSER_W-1:0]   m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ioc_pkg::CAP_W-1:0]     cfg_data_i
);
  import ioc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RET  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [NW-1:0] nn);
    logic [NW-1:0] q;
    q = NW'(p) + NW'(1);
    return (q >= nn) ? '0 : q[AW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [AW-1:0]   head_q, head_d, disp_q, disp_d, ret_q, ret_d;
  logic [NW-1:0]   pend_q, pend_d, undisp_q, undisp_d;
  logic [AW-1:0]   walk_p_q, walk_p_d;
  logic [NW-1:0]   walk_cnt_q, walk_cnt_d;
  ioc_res_t        res_q, res_d;
  logic            use_rd_q, use_rd_d;

  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic                  done_mem [DEPTH];
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic                  done_rd_q;

  logic            data_we, data_re;
  logic            done_we, done_wval, done_re;
  logic [AW-1:0]   done_waddr, done_raddr;

  logic [NW-1:0]   cap_ext, n, in_flight, slot_ext;
  logic [NW:0]     off_sum, off;
  ioc_action_e     action;
  logic            accept;
  ioc_res_t        emit_res;
  logic            emit_ready;

  assign action    = ioc_action_e'(s_axis_tuser[1:0]);
  assign cap_ext   = NW'(cap_q);
  assign n         = (cap_q == '0) ? NW'(1) :
                     ((cap_ext > NW'(DEPTH)) ? NW'(DEPTH) : cap_ext);
  assign in_flight = pend_q - undisp_q;
  assign slot_ext  = NW'(s_axis_tdata[71:64]);
  assign off_sum   = (NW+1)'(slot_ext) + (NW+1)'(n) - (NW+1)'(ret_q);
  assign off       = (off_sum >= (NW+1)'(n)) ? off_sum - (NW+1)'(n) : off_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d    = state_q;
    cap_d      = cap_q;
    head_d     = head_q;
    disp_d     = disp_q;
    ret_d      = ret_q;
    pend_d     = pend_q;
    undisp_d   = undisp_q;
    walk_p_d   = walk_p_q;
    walk_cnt_d = walk_cnt_q;
    res_d      = res_q;
    use_rd_d   = use_rd_q;
    data_we    = 1'b0;
    data_re    = 1'b0;
    done_we    = 1'b0;
    done_wval  = 1'b0;
    done_waddr = head_q;
    done_re    = 1'b0;
    done_raddr = ret_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d    = '{status: ST_OK, out_slot: '0, out_value: '0, retired_count: '0};
          use_rd_d = 1'b0;
          state_d  = S_EMIT;
          case (action)
            ACT_PUSH: begin
              if (pend_q >= n) begin
                res_d.status = ST_FULL;
              end else begin
                data_we        = 1'b1;
                done_we        = 1'b1;
                done_wval      = 1'b0;
                done_waddr     = head_q;
                res_d.out_slot = SLOT_W'(head_q);
                head_d         = adv(head_q, n);
                pend_d         = pend_q + NW'(1);
                undisp_d       = undisp_q + NW'(1);
              end
            end
            ACT_DISPATCH: begin
              if (undisp_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                data_re        = 1'b1;
                use_rd_d       = 1'b1;
                res_d.out_slot = SLOT_W'(disp_q);
                disp_d         = adv(disp_q, n);
                undisp_d       = undisp_q - NW'(1);
              end
            end
            ACT_COMPLETE: begin
              if (slot_ext >= n) begin
                res_d.status = ST_RANGE;
              end else if (off < (NW+1)'(in_flight)) begin
                done_we    = 1'b1;
                done_wval  = 1'b1;
                done_waddr = slot_ext[AW-1:0];
              end
            end
            ACT_RETIRE: begin
              done_re    = 1'b1;
              done_raddr = ret_q;
              walk_p_d   = ret_q;
              walk_cnt_d = '0;
              state_d    = S_RET;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_RET: begin
        if ((walk_cnt_q < in_flight) && done_rd_q) begin
          walk_cnt_d = walk_cnt_q + NW'(1);
          walk_p_d   = adv(walk_p_q, n);
          done_re    = 1'b1;
          done_raddr = walk_p_d;
        end else begin
          ret_d               = walk_p_q;
          pend_d              = pend_q - walk_cnt_q;
          res_d.retired_count = CNT_W'(walk_cnt_q);
          state_d             = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d    = cfg_data_i;
      head_d   = '0;
      disp_d   = '0;
      ret_d    = '0;
      pend_d   = '0;
      undisp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cap_q      <= CAP_RESET;
      head_q     <= '0;
      disp_q     <= '0;
      ret_q      <= '0;
      pend_q     <= '0;
      undisp_q   <= '0;
      walk_p_q   <= '0;
      walk_cnt_q <= '0;
      use_rd_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cap_q      <= cap_d;
      head_q     <= head_d;
      disp_q     <= disp_d;
      ret_q      <= ret_d;
      pend_q     <= pend_d;
      undisp_q   <= undisp_d;
      walk_p_q   <= walk_p_d;
      walk_cnt_q <= walk_cnt_d;
      use_rd_q   <= use_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // slot data: written on push, read on dispatch
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[head_q] <= s_axis_tdata[DATA_WIDTH-1:0];
    end
    if (data_re) begin
      data_rd_q <= data_mem[disp_q];
    end
  end

  // done bits: only bits of slots pushed since the last clear ever decide a retire
  always_ff @(posedge clk_i) begin
    if (done_we) begin
      done_mem[done_waddr] <= done_wval;
    end
    if (done_re) begin
      done_rd_q <= done_mem[done_raddr];
    end
  end

  always_comb begin
    emit_res           = res_q;
    emit_res.out_value = use_rd_q ? VAL_W'(data_rd_q) : '0;
  end

  ioc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (state_q == S_EMIT),
    .res_i       (emit_res),
    .res_ready_o (emit_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

`ifndef SYNTH
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q >= undisp_q) && (pend_q <= NW'(DEPTH)))
    else $error("pending count below undispatched count or above depth");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RET) |-> (walk_cnt_q <= in_flight))
    else $error("retire walk passed the in-flight window");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while previous word still in progress");
`endif

endmodule

/* rtl/ioc_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_out_stage
// Output register of the result stream; packs a result word into tdata/tuser.
// ----------------------------------------------------------------------------
module ioc_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  input  ioc_pkg::ioc_res_t                 res_i,
  output logic                              res_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  // out_slot[7:0], out_value[71:8], retired_count[80:72], zero fill
  output logic [ioc_pkg::M_TDATA_W-1:0]     out_data_o,
  // status[1:0]
  output logic [ioc_pkg::TUSER_W-1:0]       out_user_o
);
  import ioc_pkg::*;

  logic     vld_q, vld_d;
  ioc_res_t data_q;

  assign res_ready_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = {(M_TDATA_W - SLOT_W - VAL_W - CNT_W)'(0),
                        data_q.retired_count, data_q.out_value, data_q.out_slot};
  assign out_user_o  = data_q.status;

endmodule
